>>> rtl/core/sttu_pkg.sv
package sttu_pkg;

  // Operation codes carried in the input transaction
  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_START       = 3'd1;
  localparam logic [2:0] OP_STOP        = 3'd2;
  localparam logic [2:0] OP_START_DELAY = 3'd3;
  localparam logic [2:0] OP_START_WAKE  = 3'd4;
  localparam logic [2:0] OP_STOP_WAKE   = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_MS_UNIT     = 2'd0;
  localparam logic [1:0] REG_SEC_PERIOD  = 2'd1;
  localparam logic [1:0] REG_WAKE_PERIOD = 2'd2;

  // Register reset values
  localparam logic [15:0] MS_UNIT_RESET     = 16'd32;
  localparam logic [15:0] SEC_PERIOD_RESET  = 16'd32767;
  localparam logic [15:0] WAKE_PERIOD_RESET = 16'd0;

  // Milliseconds per second
  localparam logic [31:0] MS_PER_SEC = 32'd1000;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] delay_ms;
  } in_item_t;

  typedef struct packed {
    logic [31:0] ms_count;
    logic [31:0] sec_count;
    logic        delay_busy;
    logic        wake_pulse;
  } out_item_t;

  // Configuration write as seen by the core
  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

  // Result push from the core into the output queue
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } push_t;

endpackage

>>> rtl/core/sttu_out_fifo.sv
module sttu_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  sttu_pkg::push_t    push,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output sttu_pkg::out_item_t out_data
);

  sttu_pkg::out_item_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entry[rd_ptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = out_valid && !out_stall;

  // Pointer and occupancy bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push.item;
  end

endmodule

>>> rtl/core/sttu_core.sv
module sttu_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sttu_pkg::in_item_t in_data,
  input  sttu_pkg::cfg_wr_t  cfg,
  input  logic               fifo_full,
  output sttu_pkg::push_t    push
);

  // Input register
  logic               item_valid;
  sttu_pkg::in_item_t item;

  // Configuration registers
  logic [15:0] ms_unit;
  logic [15:0] sec_period;
  logic [15:0] wake_period;

  // Timer state
  logic [15:0] counter,      counter_next;
  logic [15:0] ms_compare,   ms_compare_next;
  logic        running,      running_next;
  logic [31:0] ms_ticks,     ms_ticks_next;
  logic [31:0] sec_ticks,    sec_ticks_next;
  logic [31:0] sec_ms,       sec_ms_next;     // sec_ticks * 1000, kept incrementally
  logic        delay_on,     delay_on_next;
  logic [15:0] delay_count,  delay_count_next;
  logic [15:0] delay_length, delay_length_next;
  logic        wake_on,      wake_on_next;
  logic [15:0] wake_count,   wake_count_next;
  logic        pulse;

  logic advance;

  assign advance  = item_valid && !fifo_full;
  assign in_stall = item_valid && fifo_full;

  // Next state for the held operation
  always_comb begin
    logic [15:0] counter_adv;
    logic        sec_hit;
    logic        ms_hit;
    logic [31:0] ms_base;
    logic [15:0] cmp_base;
    logic [15:0] wake_inc;
    logic [15:0] delay_inc;

    counter_adv = (counter == sec_period) ? 16'd0 : counter + 16'd1;
    sec_hit     = (counter_adv == sec_period);
    ms_hit      = (counter_adv == ms_compare);
    wake_inc    = wake_count + 16'd1;
    delay_inc   = delay_count + 16'd1;
    ms_base     = ms_ticks;
    cmp_base    = ms_compare;

    counter_next      = counter;
    ms_compare_next   = ms_compare;
    running_next      = running;
    ms_ticks_next     = ms_ticks;
    sec_ticks_next    = sec_ticks;
    sec_ms_next       = sec_ms;
    delay_on_next     = delay_on;
    delay_count_next  = delay_count;
    delay_length_next = delay_length;
    wake_on_next      = wake_on;
    wake_count_next   = wake_count;
    pulse             = 1'b0;

    case (item.operation)
      sttu_pkg::OP_TICK: begin
        if (running) begin
          counter_next = counter_adv;
          // second event first
          if (sec_hit) begin
            sec_ticks_next  = sec_ticks + 32'd1;
            sec_ms_next     = sec_ms + sttu_pkg::MS_PER_SEC;
            ms_base         = sec_ms + sttu_pkg::MS_PER_SEC;
            cmp_base        = ms_unit;
            ms_ticks_next   = ms_base;
            ms_compare_next = cmp_base;
            if (wake_on) begin
              if (wake_inc >= wake_period) begin
                wake_count_next = 16'd0;
                pulse           = 1'b1;
              end else begin
                wake_count_next = wake_inc;
              end
            end
          end
          // then the millisecond event
          if (ms_hit) begin
            ms_ticks_next   = ms_base + 32'd1;
            ms_compare_next = cmp_base + ms_unit;
            if (delay_on) begin
              delay_count_next = delay_inc;
              if (delay_inc >= delay_length) delay_on_next = 1'b0;
            end
          end
        end
      end
      sttu_pkg::OP_START: begin
        ms_ticks_next  = 32'd0;
        sec_ticks_next = 32'd0;
        sec_ms_next    = 32'd0;
        counter_next   = 16'd0;
        running_next   = 1'b1;
      end
      sttu_pkg::OP_STOP: begin
        ms_ticks_next  = 32'd0;
        sec_ticks_next = 32'd0;
        sec_ms_next    = 32'd0;
        counter_next   = 16'd0;
        running_next   = 1'b0;
      end
      sttu_pkg::OP_START_DELAY: begin
        delay_length_next = item.delay_ms;
        delay_count_next  = 16'd0;
        delay_on_next     = 1'b1;
      end
      sttu_pkg::OP_START_WAKE: begin
        wake_count_next = 16'd0;
        wake_on_next    = 1'b1;
      end
      sttu_pkg::OP_STOP_WAKE: begin
        wake_count_next = 16'd0;
        wake_on_next    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Result toward the output queue
  always_comb begin
    push.valid           = advance;
    push.item.ms_count   = ms_ticks_next;
    push.item.sec_count  = sec_ticks_next;
    push.item.delay_busy = delay_on_next;
    push.item.wake_pulse = pulse;
  end

  // Input register: loads whenever it is not stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) item <= in_data;
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ms_unit      <= sttu_pkg::MS_UNIT_RESET;
      sec_period   <= sttu_pkg::SEC_PERIOD_RESET;
      wake_period  <= sttu_pkg::WAKE_PERIOD_RESET;
      counter      <= 16'd0;
      ms_compare   <= sttu_pkg::MS_UNIT_RESET;
      running      <= 1'b0;
      ms_ticks     <= 32'd0;
      sec_ticks    <= 32'd0;
      sec_ms       <= 32'd0;
      delay_on     <= 1'b0;
      delay_count  <= 16'd0;
      delay_length <= 16'd0;
      wake_on      <= 1'b0;
      wake_count   <= 16'd0;
    end else begin
      if (advance) begin
        counter      <= counter_next;
        ms_compare   <= ms_compare_next;
        running      <= running_next;
        ms_ticks     <= ms_ticks_next;
        sec_ticks    <= sec_ticks_next;
        sec_ms       <= sec_ms_next;
        delay_on     <= delay_on_next;
        delay_count  <= delay_count_next;
        delay_length <= delay_length_next;
        wake_on      <= wake_on_next;
        wake_count   <= wake_count_next;
      end
      // user writes only while idle (not enforced); ms_unit writes reload the compare
      if (cfg.valid) begin
        case (cfg.index)
          sttu_pkg::REG_MS_UNIT: begin
            ms_unit    <= cfg.data;
            ms_compare <= cfg.data;
          end
          sttu_pkg::REG_SEC_PERIOD:  sec_period  <= cfg.data;
          sttu_pkg::REG_WAKE_PERIOD: wake_period <= cfg.data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/core/system_tick_timer_unit.sv
// System tick timer with millisecond compare. Each input transaction is one
// operation of the timer clock (tick, start, stop, start delay, start wake,
// stop wake) and yields exactly one result transaction carrying the
// millisecond count, second count, delay busy flag and wake pulse as they
// stand after that operation. One operation is accepted every cycle unless the
// input stalls; it passes the input register, then the state update, which
// writes its result into a two-entry output queue that offers it at the output.
// The state update loop sets this rate; the input stalls only when the output
// queue is full and its holder is loaded.
// Configuration registers (0 ms_unit, 1 sec_period, 2 wake_period) are
// written through the cfg port, which is always ready; writes belong in idle
// time, and a write to ms_unit also reloads the millisecond compare.
module system_tick_timer_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sttu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sttu_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  sttu_pkg::cfg_wr_t cfg;
  sttu_pkg::push_t   push;
  logic              fifo_full;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  sttu_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg),
    .fifo_full (fifo_full),
    .push      (push)
  );

  sttu_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Input stalls only while results are backed up
  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output queue");

  // The core never pushes into a full queue
  a_no_lost_push: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && fifo_full))
    else $error("result pushed into full output queue");

  // Reset empties the path
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("path not empty after reset");

endmodule
